// ===== rtl/mm3h_pkg.sv =====
// shared constants, types and helpers for the murmur3 stream hash
`default_nettype none
package mm3h_pkg;

   localparam int unsigned HashWidth  = 32;
   localparam int unsigned CountWidth = 3;

   localparam logic [HashWidth-1:0] MixC1  = 32'hcc9e2d51;
   localparam logic [HashWidth-1:0] MixC2  = 32'h1b873593;
   localparam logic [HashWidth-1:0] MixAdd = 32'he6546b64;
   localparam logic [HashWidth-1:0] FinC1  = 32'h85ebca6b;
   localparam logic [HashWidth-1:0] FinC2  = 32'hc2b2ae35;

   localparam logic [CountWidth-1:0] FullBytes = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic load;      // take a new word and do the first multiply
      logic mul2;      // rotate and second multiply
      logic mix;       // fold into the running hash
      logic fin1;      // first avalanche multiply
      logic fin2;      // second avalanche multiply
      logic out_load;  // last shift-xor into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;
   } status_type;

   function automatic logic [HashWidth-1:0] rotl(input logic [HashWidth-1:0] v,
                                                input int unsigned r);
      rotl = (v << r) | (v >> (HashWidth - r));
   endfunction

endpackage
`default_nettype wire

// ===== rtl/mm3h_dpath.sv =====
// datapath: word scramble, hash update, byte count and final avalanche
`default_nettype none
module mm3h_dpath
   import mm3h_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output      status_type            status,
   input  wire logic [HashWidth-1:0]  key_word,
   input  wire logic [CountWidth-1:0] valid_bytes,
   input  wire logic                  last_word,
   input  wire logic                  csr_wr_en,
   input  wire logic [HashWidth-1:0]  csr_wr_data,
   output      logic [HashWidth-1:0]  hash_value
);

   logic [HashWidth-1:0]  seed_ff;
   logic [HashWidth-1:0]  h_ff, h_in;
   logic [HashWidth-1:0]  total_ff, total_in;
   logic [HashWidth-1:0]  k_ff, k_in;
   logic [HashWidth-1:0]  f_ff, f_in;
   logic [CountWidth-1:0] n_ff;
   logic                  last_ff;
   logic [HashWidth-1:0]  out_ff;

   logic [CountWidth-1:0] n_clamp;
   logic [HashWidth-1:0]  word_masked;
   logic [HashWidth-1:0]  h_xor, h_rot, h_mixed;

   always_comb begin
      n_clamp = (valid_bytes > FullBytes) ? FullBytes : valid_bytes;
      case (n_clamp)
         3'd0: word_masked = '0;
         3'd1: word_masked = {24'd0, key_word[7:0]};
         3'd2: word_masked = {16'd0, key_word[15:0]};
         3'd3: word_masked = {8'd0, key_word[23:0]};
         default: word_masked = key_word;
      endcase
   end

   // full words rotate and offset, partial words only xor in
   always_comb begin
      h_xor   = h_ff ^ k_ff;
      h_rot   = rotl(h_xor, 13);
      h_mixed = (n_ff == FullBytes) ? ((h_rot << 2) + h_rot + MixAdd) : h_xor;
      total_in = total_ff + {{(HashWidth-CountWidth){1'b0}}, n_ff};
      h_in = h_mixed;
      k_in = k_ff;
      f_in = f_ff;
      if (cmd.load) begin
         k_in = word_masked * MixC1;
      end else if (cmd.mul2) begin
         k_in = rotl(k_ff, 15) * MixC2;
      end
      if (cmd.mix) begin
         f_in = h_mixed ^ total_in;
      end else if (cmd.fin1) begin
         f_in = (f_ff ^ (f_ff >> 16)) * FinC1;
      end else if (cmd.fin2) begin
         f_in = (f_ff ^ (f_ff >> 13)) * FinC2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= '0;
         h_ff     <= '0;
         total_ff <= '0;
         last_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         seed_ff  <= csr_wr_data;
         h_ff     <= csr_wr_data;
         total_ff <= '0;
      end else begin
         if (cmd.load) begin
            last_ff <= last_word;
         end
         if (cmd.mix) begin
            if (last_ff) begin
               h_ff     <= seed_ff;
               total_ff <= '0;
            end else begin
               h_ff     <= h_in;
               total_ff <= total_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff <= n_clamp;
      end
      k_ff <= k_in;
      f_ff <= f_in;
      if (cmd.out_load) begin
         out_ff <= f_ff ^ (f_ff >> 16);
      end
   end

   assign status.last = last_ff;
   assign hash_value  = out_ff;

endmodule
`default_nettype wire

// ===== rtl/mm3h_ctrl.sv =====
// controller: sequences one word through the datapath and owns the handshakes
`default_nettype none
module mm3h_ctrl
   import mm3h_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   output      logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire status_type status,
   output      cmd_type    cmd
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StMul2  = 3'd1;
   localparam logic [2:0] StMix   = 3'd2;
   localparam logic [2:0] StFin1  = 3'd3;
   localparam logic [2:0] StFin2  = 3'd4;
   localparam logic [2:0] StFinal = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      case (state_ff)
         StIdle: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = StMul2;
            end
         end
         StMul2: begin
            cmd.mul2 = 1'b1;
            state_in = StMix;
         end
         StMix: begin
            cmd.mix  = 1'b1;
            state_in = status.last ? StFin1 : StIdle;
         end
         StFin1: begin
            cmd.fin1 = 1'b1;
            state_in = StFin2;
         end
         StFin2: begin
            cmd.fin2 = 1'b1;
            state_in = StFinal;
         end
         StFinal: begin
            // wait here until the output register can take the word
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/murmur3_stream_hash.sv =====
// top level of the streaming murmur3 x86_32 hash
//
//  port group | direction | carries
//  req_*      | in        | key word, valid byte count, last flag
//  rsp_*      | out       | finished 32-bit hash, one per key
//  csr_*      | in        | hash seed write
//
// a word passes through load multiply, second multiply and hash update; a last
// word then goes on through the avalanche multiplies and the output load.
// reset clears the seed, running hash and byte count; a seed write restarts the key.
// the finished hash sits in an output register, so the next key is accepted
// while it waits; only a second finished hash waits for rsp_tready.
`default_nettype none
module murmur3_stream_hash
   import mm3h_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [HashWidth-1:0]  req_tdata,   // key_word[31:0]
   input  wire logic [CountWidth-1:0] req_tuser,   // valid_bytes[2:0]
   input  wire logic                  req_tlast,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [HashWidth-1:0]  rsp_tdata,   // hash_value[31:0]
   input  wire logic                  csr_wr_en,
   input  wire logic [HashWidth-1:0]  csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   mm3h_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mm3h_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .key_word    (req_tdata),
      .valid_bytes (req_tuser),
      .last_word   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .hash_value  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== tb/sv/tb_murmur3_stream_hash.sv =====
// testbench for the streaming murmur3 x86_32 hash: seeded keys checked against a local model
`default_nettype none
module tb_murmur3_stream_hash;
   import mm3h_pkg::*;

   typedef struct {
      logic [HashWidth-1:0]  word;
      logic [CountWidth-1:0] nbytes;
      logic                  last;
   } key_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [HashWidth-1:0]  req_tdata = '0;   // key_word[31:0]
   logic [CountWidth-1:0] req_tuser = '0;   // valid_bytes[2:0]
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [HashWidth-1:0]  rsp_tdata;       // hash_value[31:0]
   logic                  csr_wr_en = 1'b0;
   logic [HashWidth-1:0]  csr_wr_data = '0;

   // model state
   logic [HashWidth-1:0] seed_shadow = '0;
   logic [HashWidth-1:0] key_hash = '0;
   logic [HashWidth-1:0] key_bytes = '0;

   key_word_type         words_to_send[$];
   logic [HashWidth-1:0] hashes_due[$];
   key_word_type         cur_word;

   bit send_idle_en = 1'b0;
   bit rsp_idle_en = 1'b0;
   int send_gap = 0;
   int rsp_stall = 0;
   int hold_reqs = 0;
   int holds_done = 0;
   int error_count = 0;

   murmur3_stream_hash DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [HashWidth-1:0] scramble_word(logic [HashWidth-1:0] k);
      logic [HashWidth-1:0] t;
      t = k * MixC1;
      t = {t[16:0], t[31:17]};
      scramble_word = t * MixC2;
   endfunction

   function automatic logic [HashWidth-1:0] finalize_hash(logic [HashWidth-1:0] h);
      logic [HashWidth-1:0] t;
      t = h ^ (h >> 16);
      t = t * FinC1;
      t = t ^ (t >> 13);
      t = t * FinC2;
      finalize_hash = t ^ (t >> 16);
   endfunction

   // fold one accepted word into the running hash, queue the digest on a last word
   task automatic absorb_word(input key_word_type w);
      logic [HashWidth-1:0]  h;
      logic [HashWidth-1:0]  mask;
      logic [CountWidth-1:0] n;
      h = key_hash;
      n = (w.nbytes > FullBytes) ? FullBytes : w.nbytes;
      if (n == FullBytes) begin
         h = h ^ scramble_word(w.word);
         h = {h[18:0], h[31:19]};
         h = h * 32'd5 + MixAdd;
      end else if (n != 3'd0) begin
         mask = 32'hffffffff >> (5'd8 * (3'd4 - n));
         h = h ^ scramble_word(w.word & mask);
      end
      key_bytes = key_bytes + {{(HashWidth-CountWidth){1'b0}}, n};
      if (!w.last) begin
         key_hash = h;
      end else begin
         hashes_due = {hashes_due, finalize_hash(h ^ key_bytes)};
         key_hash = seed_shadow;
         key_bytes = '0;
      end
   endtask

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap(bit en);
      int r;
      r = $urandom_range(0, 99);
      if (!en || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) absorb_word(cur_word);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (words_to_send.size() > 0) begin
               cur_word = words_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= cur_word.word;
               req_tuser <= cur_word.nbytes;
               req_tlast <= cur_word.last;
               send_gap = pick_gap(send_idle_en);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (hashes_due.size() == 0) begin
               error_count++;
               $display("%0t: hash with none pending, actual %h", $time, rsp_tdata);
            end else if (hashes_due[0] !== rsp_tdata) begin
               error_count++;
               $display("%0t: hash mismatch, expected %h actual %h",
                        $time, hashes_due[0], rsp_tdata);
               void'(hashes_due.pop_front());
            end else begin
               void'(hashes_due.pop_front());
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else if (holds_done != hold_reqs) begin
            // long hold-off so the output register and pipeline back up
            holds_done++;
            rsp_stall = 300;
            rsp_tready <= 1'b0;
         end else begin
            rsp_stall = pick_gap(rsp_idle_en);
            if (rsp_stall == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               rsp_stall--;
            end
         end
      end
   end

   task automatic queue_word(input logic [HashWidth-1:0] w, input int n, input bit last);
      key_word_type kw;
      kw.word = w;
      kw.nbytes = n[CountWidth-1:0];
      kw.last = last;
      words_to_send = {words_to_send, kw};
   endtask

   // split a key of len bytes into words; garbage above the valid bytes
   task automatic queue_key(input int len);
      int left;
      left = len;
      if (len == 0) begin
         queue_word($urandom, 0, 1'b1);
      end else begin
         while (left > 0) begin
            queue_word($urandom, (left >= 4) ? 4 : left, left <= 4);
            left -= 4;
         end
      end
   endtask

   task automatic queue_random(input int words);
      int start;
      int len;
      start = words_to_send.size();
      while (words_to_send.size() - start < words) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: any byte count, any last flag
            queue_word($urandom, $urandom_range(0, 7), $urandom_range(0, 1) == 1);
         end else begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 48)
                                               : $urandom_range(0, 16);
            queue_key(len);
         end
      end
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (words_to_send.size() != 0 || req_tvalid || hashes_due.size() != 0)
         @(posedge clock);
      // words without a result may still be in flight
      repeat (12) @(posedge clock);
   endtask

   task automatic write_seed(input logic [HashWidth-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      seed_shadow = v;
      key_hash = v;
      key_bytes = '0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset seed
      @(negedge clock);
      queue_word(32'hffffffff, 0, 1'b1);
      queue_word(32'hffffffff, 1, 1'b1);
      queue_word(32'hffffffff, 2, 1'b1);
      queue_word(32'hffffffff, 3, 1'b1);
      queue_word(32'hffffffff, 4, 1'b1);
      queue_word(32'h00000000, 4, 1'b1);
      queue_word(32'h00000000, 3, 1'b1);
      queue_word(32'h12345678, 5, 1'b1);
      queue_word(32'h9abcdef0, 6, 1'b0);
      queue_word(32'h0badf00d, 7, 1'b1);
      queue_word(32'hdeadbeef, 0, 1'b0);
      queue_word(32'hcafef00d, 4, 1'b0);
      queue_word(32'h55aa55aa, 0, 1'b1);
      queue_word(32'h87654321, 2, 1'b0);
      queue_word(32'h0f0f0f0f, 4, 1'b1);
      queue_word(32'h01020304, 4, 1'b0);
      queue_word(32'h05060708, 4, 1'b0);
      queue_word(32'h090a0b0c, 1, 1'b1);
      queue_word(32'hfedcba98, 4, 1'b0);
      wait_idle();
      // seed write with a key half done abandons it
      write_seed(32'hffffffff);

      @(negedge clock);
      send_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      queue_word(32'hffffffff, 4, 1'b1);
      queue_word(32'h00000000, 0, 1'b1);
      queue_random(130);
      wait_idle();
      write_seed(32'h00000000);

      @(negedge clock);
      send_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      queue_random(130);
      wait_idle();
      write_seed(32'h80000001);

      // pressure: receiver holds off while the sender keeps offering short keys
      @(negedge clock);
      hold_reqs <= hold_reqs + 1;
      repeat (60) queue_key($urandom_range(0, 4));
      wait_idle();
      write_seed($urandom);

      @(negedge clock);
      send_idle_en = 1'b1;
      rsp_idle_en = 1'b0;
      queue_random(130);
      wait_idle();
      write_seed($urandom);

      @(negedge clock);
      send_idle_en = 1'b0;
      rsp_idle_en = 1'b1;
      queue_random(130);
      wait_idle();

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #3000000;
      $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire
